/* hdl/coefficient_compress_pack_defines.svh */
// assertion macros for coefficient_compress_pack
`ifndef COEFFICIENT_COMPRESS_PACK_DEFINES_SVH
`define COEFFICIENT_COMPRESS_PACK_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CCP_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ccp assertion failed: same cycle");

`define CCP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ccp assertion failed: next cycle");

`else

`define CCP_ASSERT_IMPLY(label, clk, rst, pre, post)

`define CCP_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* hdl/ccp_pkg.sv */
package ccp_pkg;

   localparam int COEFF_WIDTH  = 14;
   localparam int GROUP_SIZE   = 8;
   localparam int WIDE_BITS    = 4;
   localparam int NARROW_BITS  = 3;
   localparam int NUM_WIDTH    = COEFF_WIDTH + WIDE_BITS + 1;
   localparam int PACKED_WIDTH = 32;
   localparam int COUNT_WIDTH  = 3;
   localparam int CSR_WIDTH    = 3;

   localparam logic [CSR_WIDTH-1:0]   WIDE_SELECT  = 3'd4;
   localparam logic [CSR_WIDTH-1:0]   CSR_RESET    = 3'd3;
   localparam logic [COUNT_WIDTH-1:0] BYTES_NARROW = 3'd3;
   localparam logic [COUNT_WIDTH-1:0] BYTES_WIDE   = 3'd4;

   typedef logic [COEFF_WIDTH-1:0] coeff_type;
   typedef logic [WIDE_BITS-1:0]   value_type;

   typedef struct packed {
      logic valid;
      logic wide;
   } stage_ctl_type;

endpackage

/* hdl/ccp_lane.sv */
module ccp_lane #(
   parameter int MODULUS = 12289
) (
   input  logic               clock,
   input  ccp_pkg::coeff_type coeff,
   input  logic               wide,
   output ccp_pkg::value_type value
);

   localparam int NUM_WIDTH   = ccp_pkg::NUM_WIDTH;
   localparam int SHIFT       = NUM_WIDTH + $clog2(MODULUS);
   localparam int RECIP_WIDTH = NUM_WIDTH + 1;
   localparam int PROD_WIDTH  = NUM_WIDTH + RECIP_WIDTH;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
   localparam logic [RECIP_WIDTH-1:0] RECIP = RECIP_FULL[RECIP_WIDTH-1:0];
   localparam logic [NUM_WIDTH-1:0]   HALF  = NUM_WIDTH'(MODULUS / 2);

   logic [NUM_WIDTH-1:0]  shifted;
   logic [NUM_WIDTH-1:0]  num_in,  num_ff;
   logic [PROD_WIDTH-1:0] prod_in, prod_ff;
   ccp_pkg::value_type    value_in, value_ff;

   // scale by 2^d and add half the modulus
   always_comb begin
      if (wide) begin
         shifted = {1'b0, coeff, 4'b0000};
      end else begin
         shifted = {2'b00, coeff, 3'b000};
      end
      num_in = shifted + HALF;
   end

   // divide by the modulus through an exact reciprocal
   assign prod_in  = PROD_WIDTH'(num_ff) * PROD_WIDTH'(RECIP);
   assign value_in = prod_ff[SHIFT +: ccp_pkg::WIDE_BITS];

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* hdl/ccp_pack.sv */
module ccp_pack (
   input  logic                                clock,
   input  logic                                reset,
   input  ccp_pkg::stage_ctl_type              ctl,
   input  ccp_pkg::value_type                  values [ccp_pkg::GROUP_SIZE],
   output logic                                valid,
   output logic [ccp_pkg::PACKED_WIDTH-1:0]    packed_bytes,
   output logic [ccp_pkg::COUNT_WIDTH-1:0]     byte_count
);

   logic                              valid_ff;
   logic [ccp_pkg::PACKED_WIDTH-1:0]  packed_in, packed_ff;
   logic [ccp_pkg::COUNT_WIDTH-1:0]   count_in,  count_ff;

   always_comb begin
      packed_in = '0;
      for (int j = 0; j < ccp_pkg::GROUP_SIZE; j++) begin
         if (ctl.wide) begin
            packed_in[ccp_pkg::WIDE_BITS*j +: ccp_pkg::WIDE_BITS] = values[j];
         end else begin
            packed_in[ccp_pkg::NARROW_BITS*j +: ccp_pkg::NARROW_BITS] =
               values[j][ccp_pkg::NARROW_BITS-1:0];
         end
      end
      count_in = ctl.wide ? ccp_pkg::BYTES_WIDE : ccp_pkg::BYTES_NARROW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
      packed_ff <= packed_in;
      count_ff  <= count_in;
   end

   assign valid        = valid_ff;
   assign packed_bytes = packed_ff;
   assign byte_count   = count_ff;

endmodule

/* hdl/coefficient_compress_pack.sv */
// channel   ports                                   handshake
// request   req_coeff_0 .. req_coeff_7               start, busy
// response  rsp_packed_bytes, rsp_byte_count         rsp_valid strobe
// config    csr_write_data                          csr_write_enable
//
// one item per cycle while busy is low; each item passes through the stages below in order
// stages: scale and round offset, reciprocal multiply, quotient select, pack
// busy is high only during reset, which loads CSR_RESET into the config and clears all valid bits
// results cannot be held off, so the pipeline never stalls
`include "coefficient_compress_pack_defines.svh"

module coefficient_compress_pack #(
   parameter int MODULUS = 12289
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_0,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_1,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_2,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_3,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_4,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_5,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_6,
   input  logic [ccp_pkg::COEFF_WIDTH-1:0]     req_coeff_7,
   output logic                                rsp_valid,
   output logic [ccp_pkg::PACKED_WIDTH-1:0]    rsp_packed_bytes,
   output logic [ccp_pkg::COUNT_WIDTH-1:0]     rsp_byte_count,
   input  logic                                csr_write_enable,
   input  logic [ccp_pkg::CSR_WIDTH-1:0]       csr_write_data
);

   logic [ccp_pkg::CSR_WIDTH-1:0] bits_per_coeff_ff;
   logic                          req_accept;
   ccp_pkg::stage_ctl_type        ctl_in, ctl_s1_ff, ctl_s2_ff, ctl_s3_ff;
   ccp_pkg::coeff_type            coeffs [ccp_pkg::GROUP_SIZE];
   ccp_pkg::value_type            values [ccp_pkg::GROUP_SIZE];

   assign busy       = reset;
   assign req_accept = start & ~busy;

   assign coeffs[0] = req_coeff_0;
   assign coeffs[1] = req_coeff_1;
   assign coeffs[2] = req_coeff_2;
   assign coeffs[3] = req_coeff_3;
   assign coeffs[4] = req_coeff_4;
   assign coeffs[5] = req_coeff_5;
   assign coeffs[6] = req_coeff_6;
   assign coeffs[7] = req_coeff_7;

   assign ctl_in.valid = req_accept;
   assign ctl_in.wide  = (bits_per_coeff_ff == ccp_pkg::WIDE_SELECT);

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_per_coeff_ff <= ccp_pkg::CSR_RESET;
         ctl_s1_ff         <= '0;
         ctl_s2_ff         <= '0;
         ctl_s3_ff         <= '0;
      end else begin
         if (csr_write_enable) begin
            bits_per_coeff_ff <= csr_write_data;
         end
         ctl_s1_ff <= ctl_in;
         ctl_s2_ff <= ctl_s1_ff;
         ctl_s3_ff <= ctl_s2_ff;
      end
   end

   for (genvar j = 0; j < ccp_pkg::GROUP_SIZE; j++) begin : g_lane
      ccp_lane #(
         .MODULUS (MODULUS)
      ) u_lane (
         .clock (clock),
         .coeff (coeffs[j]),
         .wide  (ctl_in.wide),
         .value (values[j])
      );
   end

   ccp_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl_s3_ff),
      .values       (values),
      .valid        (rsp_valid),
      .packed_bytes (rsp_packed_bytes),
      .byte_count   (rsp_byte_count)
   );

   `CCP_ASSERT_IMPLY(a_latency, clock, reset, rsp_valid, $past(req_accept, 4))
   `CCP_ASSERT_IMPLY(a_count, clock, reset, rsp_valid,
      (rsp_byte_count == ccp_pkg::BYTES_NARROW) || (rsp_byte_count == ccp_pkg::BYTES_WIDE))
   `CCP_ASSERT_IMPLY(a_narrow_top, clock, reset,
      rsp_valid && (rsp_byte_count == ccp_pkg::BYTES_NARROW), rsp_packed_bytes[31:24] == 8'd0)
   `CCP_ASSERT_NEXT(a_csr_write, clock, reset, csr_write_enable,
      bits_per_coeff_ff == $past(csr_write_data))

endmodule

/* sim/coefficient_compress_pack_test.sv */
`timescale 1ns / 1ps

module coefficient_compress_pack_test;

   localparam int MODULUS      = 12289;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_GAP      = 11;
   localparam int PHASE_ITEMS  = 64;
   localparam int COEFF_MAX    = (1 << ccp_pkg::COEFF_WIDTH) - 1;

   typedef logic [ccp_pkg::GROUP_SIZE-1:0][ccp_pkg::COEFF_WIDTH-1:0] group_type;

   typedef struct packed {
      logic [ccp_pkg::PACKED_WIDTH-1:0] packed_bytes;
      logic [ccp_pkg::COUNT_WIDTH-1:0]  byte_count;
   } packed_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   group_type                        req_group = '0;
   logic                             rsp_valid;
   logic [ccp_pkg::PACKED_WIDTH-1:0] rsp_packed_bytes;
   logic [ccp_pkg::COUNT_WIDTH-1:0]  rsp_byte_count;
   logic                             csr_write_enable = 1'b0;
   logic [ccp_pkg::CSR_WIDTH-1:0]    csr_write_data = '0;

   group_type                        pending_groups[$];
   packed_result_type                expected_packs[$];
   logic [ccp_pkg::CSR_WIDTH-1:0]    width_setting = ccp_pkg::CSR_RESET;
   logic                             took_item = 1'b0;
   int                               gap_left = 0;
   int                               max_gap = MAX_GAP;
   int                               error_count = 0;
   int                               cycle_count = 0;

   logic [ccp_pkg::CSR_WIDTH-1:0] phase_sel [11] = '{3'd0, ccp_pkg::WIDE_SELECT, 3'd7,
      ccp_pkg::CSR_RESET, ccp_pkg::WIDE_SELECT, 3'd1, 3'd2, ccp_pkg::WIDE_SELECT, 3'd5,
      3'd6, ccp_pkg::WIDE_SELECT};

   coefficient_compress_pack #(
      .MODULUS(MODULUS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_coeff_0      (req_group[0]),
      .req_coeff_1      (req_group[1]),
      .req_coeff_2      (req_group[2]),
      .req_coeff_3      (req_group[3]),
      .req_coeff_4      (req_group[4]),
      .req_coeff_5      (req_group[5]),
      .req_coeff_6      (req_group[6]),
      .req_coeff_7      (req_group[7]),
      .rsp_valid        (rsp_valid),
      .rsp_packed_bytes (rsp_packed_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned coeff_bits(logic [ccp_pkg::CSR_WIDTH-1:0] sel);
      return (sel == ccp_pkg::WIDE_SELECT) ? ccp_pkg::WIDE_BITS : ccp_pkg::NARROW_BITS;
   endfunction

   function automatic packed_result_type compress_group(group_type group,
                                                        logic [ccp_pkg::CSR_WIDTH-1:0] sel);
      int unsigned       width;
      int unsigned       num;
      int unsigned       mask;
      packed_result_type result;
      width = coeff_bits(sel);
      mask = (sel == ccp_pkg::WIDE_SELECT) ? 15 : 7;
      result.packed_bytes = '0;
      for (int j = 0; j < ccp_pkg::GROUP_SIZE; j++) begin
         num = (32'(group[j]) << width) + MODULUS / 2;
         result.packed_bytes |= ((num / MODULUS) & mask) << (width * j);
      end
      result.byte_count = (sel == ccp_pkg::WIDE_SELECT) ? ccp_pkg::BYTES_WIDE :
                                                          ccp_pkg::BYTES_NARROW;
      return result;
   endfunction

   // value next to a rounding step of the quotient
   function automatic ccp_pkg::coeff_type rounding_step(int unsigned width, int step,
                                                        int offset);
      int boundary;
      boundary = (step * MODULUS - MODULUS / 2 + (1 << width) - 1) >> width;
      boundary = boundary + offset;
      if (boundary < 0) boundary = 0;
      if (boundary > COEFF_MAX) boundary = COEFF_MAX;
      return boundary[ccp_pkg::COEFF_WIDTH-1:0];
   endfunction

   function automatic ccp_pkg::coeff_type pick_coeff(int unsigned width);
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 6) return ccp_pkg::coeff_type'($urandom_range(0, MODULUS - 1));
      if (kind < 8)
         return rounding_step(width, $urandom_range(1, 1 << width), $urandom_range(0, 2) - 1);
      return ccp_pkg::coeff_type'($urandom_range(0, COEFF_MAX));
   endfunction

   function automatic group_type random_group(logic [ccp_pkg::CSR_WIDTH-1:0] sel);
      group_type group;
      for (int j = 0; j < ccp_pkg::GROUP_SIZE; j++) group[j] = pick_coeff(coeff_bits(sel));
      return group;
   endfunction

   task automatic queue_directed(logic [ccp_pkg::CSR_WIDTH-1:0] sel);
      group_type   group;
      int unsigned width;
      width = coeff_bits(sel);
      for (int n = 0; n < 10; n++) begin
         for (int j = 0; j < ccp_pkg::GROUP_SIZE; j++) begin
            case (n)
               0: group[j] = '0;
               1: group[j] = ccp_pkg::coeff_type'(COEFF_MAX);
               2: group[j] = ccp_pkg::coeff_type'(MODULUS - 1);
               3: group[j] = ccp_pkg::coeff_type'(MODULUS);
               4: group[j] = (j % 2 == 0) ? '0 : ccp_pkg::coeff_type'(COEFF_MAX);
               5: group[j] = ccp_pkg::coeff_type'(MODULUS / 2 + j - 4);
               6: group[j] = ccp_pkg::coeff_type'((j * MODULUS) / ccp_pkg::GROUP_SIZE);
               7: group[j] = rounding_step(width, j + 1, -1);
               8: group[j] = rounding_step(width, j + 1, 0);
               default: group[j] = ccp_pkg::coeff_type'(MODULUS + j * 500);
            endcase
         end
         pending_groups.push_back(group);
      end
   endtask

   task automatic set_width(logic [ccp_pkg::CSR_WIDTH-1:0] sel);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= sel;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_groups.size() != 0 || start || expected_packs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && (!start || took_item)) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left = gap_left - 1;
         end else if (pending_groups.size() != 0) begin
            req_group <= pending_groups.pop_front();
            start <= 1'b1;
            gap_left = $urandom_range(0, max_gap);
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      packed_result_type expected;
      if (reset) begin
         width_setting <= ccp_pkg::CSR_RESET;
         took_item <= 1'b0;
      end else begin
         took_item <= start && !busy;
         if (csr_write_enable) width_setting <= csr_write_data;
         if (start && !busy) expected_packs.push_back(compress_group(req_group, width_setting));
         if (rsp_valid) begin
            if (expected_packs.size() == 0) begin
               $display("%0t: unexpected item, actual %h %0d", $time, rsp_packed_bytes,
                        rsp_byte_count);
               error_count++;
            end else begin
               expected = expected_packs.pop_front();
               if (rsp_packed_bytes !== expected.packed_bytes) begin
                  $display("%0t: packed_bytes expected %h actual %h", $time,
                           expected.packed_bytes, rsp_packed_bytes);
                  error_count++;
               end
               if (rsp_byte_count !== expected.byte_count) begin
                  $display("%0t: byte_count expected %0d actual %0d", $time,
                           expected.byte_count, rsp_byte_count);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      queue_directed(ccp_pkg::CSR_RESET);
      wait_drained();
      set_width(ccp_pkg::WIDE_SELECT);
      queue_directed(ccp_pkg::WIDE_SELECT);
      wait_drained();
      foreach (phase_sel[p]) begin
         set_width(phase_sel[p]);
         max_gap = (p % 3 == 2) ? 0 : MAX_GAP;
         repeat (PHASE_ITEMS) pending_groups.push_back(random_group(phase_sel[p]));
         wait_drained();
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
